// File: rtl/hbs_pkg.sv
// Shared types, constants and helpers for the height map bilinear sampler.
package hbs_pkg;

    localparam int MAP_DIM_MAX = 256;
    localparam int AXIS_W      = 8;
    localparam int DIM_W       = 9;
    localparam int TEXEL_W     = 16;
    localparam int COORD_W     = 17;
    localparam int INT_W       = 16;
    localparam int HEIGHT_W    = 27;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int PROD_W      = 27;
    localparam int BANK_AW     = 2 * (AXIS_W - 1);
    localparam int BANK_DEPTH  = 1 << BANK_AW;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int NORM_W      = 25;
    // rounding bias of the normalize step: (2^TEXEL_W - 1) * 256 / 2
    localparam logic [48:0] NORM_BIAS = 49'd8388480;
    localparam logic [16:0] TEXEL_MAX = 17'd65535;

    typedef enum logic [1:0] {
        REQ_WR_BASE   = 2'd0,
        REQ_WR_TRENCH = 2'd1,
        REQ_SAMPLE    = 2'd2
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_W     = 3'd0,
        CFG_BASE_H     = 3'd1,
        CFG_TRENCH_W   = 3'd2,
        CFG_TRENCH_H   = 3'd3,
        CFG_INTENSITY  = 3'd4,
        CFG_USE_TRENCH = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [DIM_W-1:0] base_width;
        logic [DIM_W-1:0] base_height;
        logic [DIM_W-1:0] trench_width;
        logic [DIM_W-1:0] trench_height;
        logic [INT_W-1:0] intensity;
        logic             use_trench;
    } cfg_t;

    typedef struct packed {
        logic [AXIS_W-1:0]  i0;
        logic [AXIS_W-1:0]  i1;
        logic [TEXEL_W-1:0] frac;
    } axis_t;

    typedef struct packed {
        axis_t x;
        axis_t y;
    } map_pos_t;

    typedef struct packed {
        logic [1:0]         req;
        logic [AXIS_W-1:0]  tx;
        logic [AXIS_W-1:0]  ty;
        logic [TEXEL_W-1:0] tv;
        map_pos_t           base;
        map_pos_t           trench;
    } q_item_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0)
            r = DIM_W'(1);
        else if (d > DIM_W'(MAP_DIM_MAX))
            r = DIM_W'(MAP_DIM_MAX);
        return r;
    endfunction

    // t = coord * dim + 1/2 in Q.16; texel pair is floor(t) - 1 and floor(t)
    function automatic axis_t clamp_axis(input logic [PROD_W-1:0] t,
                                         input logic [DIM_W-1:0] dim);
        logic signed [12:0] lo;
        logic signed [12:0] hi;
        logic signed [12:0] top;
        axis_t r;
        lo  = $signed({2'b00, t[PROD_W-1:16]}) - 13'sd1;
        hi  = lo + 13'sd1;
        top = $signed({4'b0000, dim}) - 13'sd1;
        if (lo < 0)
            lo = '0;
        if (lo > top)
            lo = top;
        if (hi > top)
            hi = top;
        r.i0   = lo[AXIS_W-1:0];
        r.i1   = hi[AXIS_W-1:0];
        r.frac = t[15:0];
        return r;
    endfunction

endpackage

// File: rtl/hbs_intf.sv
// Channel interfaces: request words, response words and configuration writes.
interface hbs_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    req_type;
    logic [hbs_pkg::AXIS_W-1:0]    texel_x;
    logic [hbs_pkg::AXIS_W-1:0]    texel_y;
    logic [hbs_pkg::TEXEL_W-1:0]   texel_value;
    logic [hbs_pkg::COORD_W-1:0]   sample_u;
    logic [hbs_pkg::COORD_W-1:0]   sample_v;
    modport source (output valid, req_type, texel_x, texel_y, texel_value, sample_u,
                    sample_v, input ready);
    modport sink (input valid, req_type, texel_x, texel_y, texel_value, sample_u,
                  sample_v, output ready);
endinterface

interface hbs_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [hbs_pkg::HEIGHT_W-1:0] height;
    modport source (output valid, height, input ready);
    modport sink (input valid, height, output ready);
endinterface

interface hbs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [hbs_pkg::CFG_IDX_W-1:0]    index;
    logic [hbs_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/hbs_front.sv
// Front end: accepts request words, computes texel coordinates, pushes to the queue.
module hbs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  hbs_pkg::cfg_t     cfg,
    hbs_req_if.sink           req,
    input  logic              q_ready,
    output logic              q_push,
    output hbs_pkg::q_item_t  q_item
);
    logic                             f_valid_reg;
    logic [1:0]                       f_req_reg;
    logic [hbs_pkg::AXIS_W-1:0]       f_tx_reg, f_ty_reg;
    logic [hbs_pkg::TEXEL_W-1:0]      f_tv_reg;
    logic [hbs_pkg::PROD_W-1:0]       f_bu_reg, f_bv_reg, f_tu_reg, f_tv2_reg;
    logic [hbs_pkg::DIM_W-1:0]        bw, bh, tw, th;
    logic                             accept;
    logic                             known;

    assign bw = hbs_pkg::eff_dim(cfg.base_width);
    assign bh = hbs_pkg::eff_dim(cfg.base_height);
    assign tw = hbs_pkg::eff_dim(cfg.trench_width);
    assign th = hbs_pkg::eff_dim(cfg.trench_height);

    assign req.ready = !f_valid_reg || q_ready;
    assign accept    = req.valid && req.ready;
    // unknown request codes are dropped here
    assign known     = (req.req_type == hbs_pkg::REQ_WR_BASE)
                    || (req.req_type == hbs_pkg::REQ_WR_TRENCH)
                    || (req.req_type == hbs_pkg::REQ_SAMPLE);
    assign q_push    = f_valid_reg && q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            f_valid_reg <= accept && known;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_req_reg <= req.req_type;
            f_tx_reg  <= req.texel_x;
            f_ty_reg  <= req.texel_y;
            f_tv_reg  <= req.texel_value;
            f_bu_reg  <= hbs_pkg::PROD_W'(req.sample_u * bw) + hbs_pkg::PROD_W'(32768);
            f_bv_reg  <= hbs_pkg::PROD_W'(req.sample_v * bh) + hbs_pkg::PROD_W'(32768);
            f_tu_reg  <= hbs_pkg::PROD_W'(req.sample_u * tw) + hbs_pkg::PROD_W'(32768);
            f_tv2_reg <= hbs_pkg::PROD_W'(req.sample_v * th) + hbs_pkg::PROD_W'(32768);
        end
    end

    always_comb
    begin
        q_item.req      = f_req_reg;
        q_item.tx       = f_tx_reg;
        q_item.ty       = f_ty_reg;
        q_item.tv       = f_tv_reg;
        q_item.base.x   = hbs_pkg::clamp_axis(f_bu_reg, bw);
        q_item.base.y   = hbs_pkg::clamp_axis(f_bv_reg, bh);
        q_item.trench.x = hbs_pkg::clamp_axis(f_tu_reg, tw);
        q_item.trench.y = hbs_pkg::clamp_axis(f_tv2_reg, th);
    end
endmodule

// File: rtl/hbs_queue.sv
// Small FIFO between the front end and the texel pipeline.
module hbs_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hbs_pkg::q_item_t  push_item,
    output logic              not_full,
    input  logic              pop,
    output logic              not_empty,
    output hbs_pkg::q_item_t  head
);
    hbs_pkg::q_item_t              mem_reg [hbs_pkg::QUEUE_DEPTH];
    logic [hbs_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [hbs_pkg::QPTR_W:0]      count_reg;

    assign not_full  = count_reg != (hbs_pkg::QPTR_W+1)'(hbs_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end
endmodule

// File: rtl/hbs_back.sv
// Back end: banked texel stores, bilinear blend, normalize and scale pipeline.
module hbs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  hbs_pkg::cfg_t     cfg,
    input  logic              q_not_empty,
    input  hbs_pkg::q_item_t  q_head,
    output logic              q_pop,
    hbs_rsp_if.source         rsp
);
    // four banks per map, selected by {row parity, column parity}
    logic [hbs_pkg::TEXEL_W-1:0] base_mem   [4][hbs_pkg::BANK_DEPTH];
    logic [hbs_pkg::TEXEL_W-1:0] trench_mem [4][hbs_pkg::BANK_DEPTH];
    logic [hbs_pkg::TEXEL_W-1:0] base_rd_reg [4];
    logic [hbs_pkg::TEXEL_W-1:0] trench_rd_reg [4];
    logic [hbs_pkg::BANK_AW-1:0] base_ra [4];
    logic [hbs_pkg::BANK_AW-1:0] trench_ra [4];
    logic [hbs_pkg::BANK_AW-1:0] waddr;
    logic [1:0]                  wbank;

    logic                        en;
    logic                        s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                        s4_valid_reg, s5_valid_reg, o_valid_reg;
    logic [3:0]                  s1_bpar_reg, s1_tpar_reg;
    logic [hbs_pkg::TEXEL_W-1:0] s1_bfx_reg, s1_bfy_reg, s1_tfx_reg, s1_tfy_reg;
    logic [hbs_pkg::TEXEL_W-1:0] s2_bfy_reg, s2_tfy_reg;
    logic [31:0]                 s2_br0_reg, s2_br1_reg, s2_tr0_reg, s2_tr1_reg;
    logic [47:0]                 s3_bsum_reg, s3_tsum_reg;
    logic [hbs_pkg::NORM_W-1:0]  s4_bn_reg, s4_tn_reg;
    logic [40:0]                 s5_pb_reg;
    logic signed [42:0]          s5_pt_reg;
    logic signed [hbs_pkg::HEIGHT_W-1:0] o_height_reg;
    logic [hbs_pkg::TEXEL_W-1:0] ba00, ba10, ba01, ba11, ta00, ta10, ta01, ta11;
    logic [hbs_pkg::NORM_W-1:0]  bn, tn;
    logic signed [25:0]          tdelta;
    logic signed [hbs_pkg::HEIGHT_W-1:0] total;
    logic [41:0]                 pb_round;
    logic signed [43:0]          pt_round;

    function automatic logic [31:0] lerp_row(input logic [15:0] a, input logic [15:0] b,
                                             input logic [15:0] f);
        logic signed [16:0] d;
        logic signed [34:0] p;
        logic signed [34:0] s;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        p = d * $signed({1'b0, f});
        s = $signed({3'b000, a, 16'h0000}) + p;
        return s[31:0];
    endfunction

    function automatic logic [47:0] lerp_col(input logic [31:0] r0, input logic [31:0] r1,
                                             input logic [15:0] f);
        logic signed [32:0] d;
        logic signed [49:0] p;
        logic signed [49:0] s;
        d = $signed({1'b0, r1}) - $signed({1'b0, r0});
        p = d * $signed({1'b0, f});
        s = $signed({2'b00, r0, 16'h0000}) + p;
        return s[47:0];
    endfunction

    // round(sum / (65535 * 256)) with a reciprocal fold for the 65535 part
    function automatic logic [hbs_pkg::NORM_W-1:0] normalize(input logic [47:0] sum);
        logic [48:0] b;
        logic [40:0] a;
        logic [24:0] q0;
        logic [25:0] r;
        logic [9:0]  q1;
        logic [16:0] r2;
        b  = {1'b0, sum} + hbs_pkg::NORM_BIAS;
        a  = b[48:8];
        q0 = a[40:16];
        r  = {10'd0, a[15:0]} + {1'b0, q0};
        q1 = r[25:16];
        r2 = {1'b0, r[15:0]} + {7'd0, q1};
        return q0 + hbs_pkg::NORM_W'(q1) + hbs_pkg::NORM_W'(r2 >= hbs_pkg::TEXEL_MAX);
    endfunction

    assign en    = !o_valid_reg || rsp.ready;
    assign q_pop = en && q_not_empty;
    assign waddr = {q_head.ty[hbs_pkg::AXIS_W-1:1], q_head.tx[hbs_pkg::AXIS_W-1:1]};
    assign wbank = {q_head.ty[0], q_head.tx[0]};

    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            base_ra[b] = {
                (q_head.base.y.i0[0] == b[1]) ? q_head.base.y.i0[hbs_pkg::AXIS_W-1:1]
                                              : q_head.base.y.i1[hbs_pkg::AXIS_W-1:1],
                (q_head.base.x.i0[0] == b[0]) ? q_head.base.x.i0[hbs_pkg::AXIS_W-1:1]
                                              : q_head.base.x.i1[hbs_pkg::AXIS_W-1:1]};
            trench_ra[b] = {
                (q_head.trench.y.i0[0] == b[1]) ? q_head.trench.y.i0[hbs_pkg::AXIS_W-1:1]
                                                : q_head.trench.y.i1[hbs_pkg::AXIS_W-1:1],
                (q_head.trench.x.i0[0] == b[0]) ? q_head.trench.x.i0[hbs_pkg::AXIS_W-1:1]
                                                : q_head.trench.x.i1[hbs_pkg::AXIS_W-1:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < 4; b++)
        begin
            if (q_pop && q_head.req == hbs_pkg::REQ_WR_BASE && wbank == b[1:0])
                base_mem[b][waddr] <= q_head.tv;
            if (en)
                base_rd_reg[b] <= base_mem[b][base_ra[b]];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < 4; b++)
        begin
            if (q_pop && q_head.req == hbs_pkg::REQ_WR_TRENCH && wbank == b[1:0])
                trench_mem[b][waddr] <= q_head.tv;
            if (en)
                trench_rd_reg[b] <= trench_mem[b][trench_ra[b]];
        end
    end

    // texel pick: corner parity bits are {y0, y1, x0, x1}
    assign ba00 = base_rd_reg[{s1_bpar_reg[3], s1_bpar_reg[1]}];
    assign ba10 = base_rd_reg[{s1_bpar_reg[3], s1_bpar_reg[0]}];
    assign ba01 = base_rd_reg[{s1_bpar_reg[2], s1_bpar_reg[1]}];
    assign ba11 = base_rd_reg[{s1_bpar_reg[2], s1_bpar_reg[0]}];
    assign ta00 = trench_rd_reg[{s1_tpar_reg[3], s1_tpar_reg[1]}];
    assign ta10 = trench_rd_reg[{s1_tpar_reg[3], s1_tpar_reg[0]}];
    assign ta01 = trench_rd_reg[{s1_tpar_reg[2], s1_tpar_reg[1]}];
    assign ta11 = trench_rd_reg[{s1_tpar_reg[2], s1_tpar_reg[0]}];

    assign bn     = normalize(s3_bsum_reg);
    assign tn     = normalize(s3_tsum_reg);
    assign tdelta = $signed({s4_tn_reg, 1'b0}) - 26'sd16777216;

    assign pb_round = {1'b0, s5_pb_reg} + 42'd32768;
    assign pt_round = s5_pt_reg + 44'sd32768;
    assign total    = $signed(hbs_pkg::HEIGHT_W'(pb_round[41:16]))
                    + pt_round[hbs_pkg::HEIGHT_W+15:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= q_pop && q_head.req == hbs_pkg::REQ_SAMPLE;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            o_valid_reg  <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_bpar_reg  <= {q_head.base.y.i0[0], q_head.base.y.i1[0],
                             q_head.base.x.i0[0], q_head.base.x.i1[0]};
            s1_tpar_reg  <= {q_head.trench.y.i0[0], q_head.trench.y.i1[0],
                             q_head.trench.x.i0[0], q_head.trench.x.i1[0]};
            s1_bfx_reg   <= q_head.base.x.frac;
            s1_bfy_reg   <= q_head.base.y.frac;
            s1_tfx_reg   <= q_head.trench.x.frac;
            s1_tfy_reg   <= q_head.trench.y.frac;

            s2_br0_reg   <= lerp_row(ba00, ba10, s1_bfx_reg);
            s2_br1_reg   <= lerp_row(ba01, ba11, s1_bfx_reg);
            s2_tr0_reg   <= lerp_row(ta00, ta10, s1_tfx_reg);
            s2_tr1_reg   <= lerp_row(ta01, ta11, s1_tfx_reg);
            s2_bfy_reg   <= s1_bfy_reg;
            s2_tfy_reg   <= s1_tfy_reg;

            s3_bsum_reg  <= lerp_col(s2_br0_reg, s2_br1_reg, s2_bfy_reg);
            s3_tsum_reg  <= lerp_col(s2_tr0_reg, s2_tr1_reg, s2_tfy_reg);

            s4_bn_reg    <= bn;
            s4_tn_reg    <= tn;

            s5_pb_reg    <= cfg.intensity * s4_bn_reg;
            s5_pt_reg    <= cfg.use_trench ? 43'(tdelta * $signed({1'b0, cfg.intensity}))
                                           : '0;

            o_height_reg <= total;
        end
    end

    assign rsp.valid  = o_valid_reg;
    assign rsp.height = o_height_reg;
endmodule

// File: rtl/heightmap_bilinear_sampler.sv
// Top level of the height map bilinear sampler.
// Takes one request word per clock while the queue has room: texel writes to the
// base or trench map, or a sample at (u,v) that returns one height word. A sample
// passes the front-end register, the queue, a five-stage back end and the output
// register. The rate is set by the texel stores, each map split into four banks by
// row and column parity, each with one read and one write port, so the four corner
// texels are read in the same cycle. Writes and samples run through the same
// in-order pipeline, so a sample always sees every earlier write. Configuration
// writes are accepted every cycle; write them only while no sample is in flight.
module heightmap_bilinear_sampler (
    input  logic       clk,
    input  logic       rst_n,
    hbs_cfg_if.sink    cfg,
    hbs_req_if.sink    req,
    hbs_rsp_if.source  rsp
);
    hbs_pkg::cfg_t    cfg_reg;
    hbs_pkg::q_item_t push_item, head;
    logic             q_push, q_pop, q_not_full, q_not_empty;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_width    <= hbs_pkg::DIM_W'(hbs_pkg::MAP_DIM_MAX);
            cfg_reg.base_height   <= hbs_pkg::DIM_W'(hbs_pkg::MAP_DIM_MAX);
            cfg_reg.trench_width  <= hbs_pkg::DIM_W'(hbs_pkg::MAP_DIM_MAX);
            cfg_reg.trench_height <= hbs_pkg::DIM_W'(hbs_pkg::MAP_DIM_MAX);
            cfg_reg.intensity     <= hbs_pkg::INT_W'(256);
            cfg_reg.use_trench    <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                hbs_pkg::CFG_BASE_W:     cfg_reg.base_width    <= cfg.data[hbs_pkg::DIM_W-1:0];
                hbs_pkg::CFG_BASE_H:     cfg_reg.base_height   <= cfg.data[hbs_pkg::DIM_W-1:0];
                hbs_pkg::CFG_TRENCH_W:   cfg_reg.trench_width  <= cfg.data[hbs_pkg::DIM_W-1:0];
                hbs_pkg::CFG_TRENCH_H:   cfg_reg.trench_height <= cfg.data[hbs_pkg::DIM_W-1:0];
                hbs_pkg::CFG_INTENSITY:  cfg_reg.intensity     <= cfg.data;
                hbs_pkg::CFG_USE_TRENCH: cfg_reg.use_trench    <= cfg.data[0];
                default:                 ;
            endcase
        end
    end

    hbs_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .req     (req),
        .q_ready (q_not_full),
        .q_push  (q_push),
        .q_item  (push_item)
    );

    hbs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head)
    );

    hbs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_head      (head),
        .q_pop       (q_pop),
        .rsp         (rsp)
    );
endmodule

// File: rtl/hbs_checker.sv
// Port-level checks for the sampler, bound to the top level.
module hbs_port_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 cfg_ready,
    input logic                                 rsp_valid,
    input logic                                 rsp_ready,
    input logic signed [hbs_pkg::HEIGHT_W-1:0]  rsp_height
);
    // a stalled response word keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_height))
        else $error("height changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port not ready");

    // nothing reaches the output in the first cycle after reset
    assert property (@(posedge clk) $rose(rst_n) |-> !rsp_valid)
        else $error("response right after reset");
endmodule

bind heightmap_bilinear_sampler hbs_port_checker u_hbs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ready  (cfg.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_height (rsp.height)
);
